// ===== sv/scc_pkg.sv =====
package scc_pkg;

  // Layer geometry
  localparam int FILTERS  = 16;
  localparam int KERNEL   = 7;
  localparam int CHANNELS = 8;

  localparam int TAPS     = FILTERS * KERNEL * CHANNELS;
  localparam int SLOTS    = KERNEL * CHANNELS;
  localparam int PER_FILT = KERNEL * CHANNELS;

  // Index widths, never narrower than one bit
  localparam int FILT_W  = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int KI_W    = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int CI_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Compare widths for the 10-bit coefficient address
  localparam int ADDR_IN_W = 10;
  localparam int WCMP_W    = (WADDR_W > ADDR_IN_W) ? WADDR_W : ADDR_IN_W;
  localparam int BCMP_W    = (FILT_W > ADDR_IN_W) ? FILT_W : ADDR_IN_W;

  // Accumulator: bias plus PER_FILT products of magnitude up to 2^30
  localparam int ACC_W = 32 + $clog2(PER_FILT + 2);

  // Request kinds carried on tuser
  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Tag that travels with each multiply through the pipeline
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [FILT_W-1:0] filt;
  } mac_tag_t;

endpackage

// ===== sv/scc_coef_mem.sv =====
module scc_coef_mem
  import scc_pkg::*;
(
  input  logic                      clk,
  input  logic                      wr_en,
  input  cmd_t                      cmd,
  input  logic [ADDR_IN_W-1:0]      coef_addr,
  input  logic signed [31:0]        coef_value,
  input  logic                      rd_en,
  input  logic [WADDR_W-1:0]        rd_waddr,
  input  logic [FILT_W-1:0]         rd_filt,
  output logic signed [15:0]        weight_q,
  output logic signed [31:0]        bias_q
);

  logic signed [15:0] wmem [TAPS];
  logic signed [31:0] bmem [FILTERS];

  logic [WCMP_W-1:0] waddr_ext;
  logic [BCMP_W-1:0] baddr_ext;
  logic              w_ok;
  logic              b_ok;

  // Range check on the incoming address; out-of-range writes are dropped
  assign waddr_ext = WCMP_W'(coef_addr);
  assign baddr_ext = BCMP_W'(coef_addr);
  assign w_ok      = waddr_ext < WCMP_W'(TAPS);
  assign b_ok      = baddr_ext < BCMP_W'(FILTERS);

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en && (cmd == CMD_WEIGHT) && w_ok) begin
      wmem[waddr_ext[WADDR_W-1:0]] <= coef_value[15:0];
    end
    if (rd_en) begin
      weight_q <= wmem[rd_waddr];
    end
  end

  // Bias memory, read in step with the weights
  always_ff @(posedge clk) begin
    if (wr_en && (cmd == CMD_BIAS) && b_ok) begin
      bmem[baddr_ext[FILT_W-1:0]] <= coef_value;
    end
    if (rd_en) begin
      bias_q <= bmem[rd_filt];
    end
  end

endmodule

// ===== sv/scc_sample_mem.sv =====
module scc_sample_mem
  import scc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                commit,
  input  logic [KI_W-1:0]     commit_row,
  input  logic                wr_en,
  input  logic [KI_W-1:0]     wr_row,
  input  logic [CI_W-1:0]     wr_ch,
  input  logic signed [15:0]  wr_data,
  input  logic                rd_en,
  input  logic [KI_W-1:0]     rd_row,
  input  logic [CI_W-1:0]     rd_ch,
  input  logic                rd_tap0,
  output logic signed [15:0]  rd_data
);

  // Ring of KERNEL time steps, one row per step
  logic signed [15:0] mem [SLOTS];
  logic [KERNEL-1:0]  row_valid;
  logic signed [15:0] data_q;
  logic               zero_q;
  logic [SADDR_W-1:0] wr_addr;
  logic [SADDR_W-1:0] rd_addr;

  assign wr_addr = SADDR_W'(wr_row * CHANNELS + wr_ch);
  assign rd_addr = SADDR_W'(rd_row * CHANNELS + rd_ch);

  // Track which history rows hold a completed step since the last clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (commit) begin
      row_valid[commit_row] <= 1'b1;
    end
  end

  // Sample storage; the current step row is always read as written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
      zero_q <= !rd_tap0 && !row_valid[rd_row];
    end
  end

  assign rd_data = zero_q ? 16'sd0 : data_q;

endmodule

// ===== sv/scc_mac.sv =====
module scc_mac
  import scc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mac_tag_t           tag1,
  input  logic signed [15:0] weight,
  input  logic signed [15:0] sample,
  input  logic signed [31:0] bias,
  output logic               adv,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,  // result[31:0], filter_index[35:32], zero pad
  output logic               m_tlast
);

  mac_tag_t                 tag2;
  logic signed [31:0]       prod;
  logic signed [31:0]       bias2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum;
  logic signed [31:0]       sat;
  logic [31:0]              res_q;
  logic [FILT_W-1:0]        filt_q;
  logic                     last_q;
  logic                     hold;
  logic                     done;

  // Stall the whole pipeline while a finished sum cannot enter the output
  assign hold = tag2.vld && tag2.last && m_tvalid && !m_tready;
  assign adv  = !hold;
  assign done = adv && tag2.vld && tag2.last;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
    end else if (adv) begin
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= weight * sample;
      bias2 <= bias;
    end
  end

  // Accumulate, loading the bias on the first tap of a filter
  always_comb begin
    if (tag2.first) begin
      sum = ACC_W'(bias2) + ACC_W'(prod);
    end else begin
      sum = acc + ACC_W'(prod);
    end
    if ((&sum[ACC_W-1:31]) || !(|sum[ACC_W-1:31])) begin
      sat = sum[31:0];
    end else if (sum[ACC_W-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag2.vld) begin
      acc <= sum;
    end
    if (done) begin
      res_q  <= sat;
      filt_q <= tag2.filt;
      last_q <= (tag2.filt == FILT_W'(FILTERS - 1));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (m_tvalid && !m_tready) || done;
    end
  end

  assign m_tdata = {4'd0, 4'(filt_q), res_q};
  assign m_tlast = last_q;

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    done |=> m_tvalid)
    else $error("finished sum did not reach the output");

  a_last_filter: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[35:32] == 4'(FILTERS - 1)))
    else $error("last marked on a filter other than the final one");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(tag2))
    else $error("pipeline moved while stalled");

endmodule

// ===== sv/streaming_causal_conv1d.sv =====
// Coefficient writes, clears and all but the final channel sample of a time step are taken while idle.
// The final sample starts a run of FILTERS*KERNEL*CHANNELS multiplies, one per cycle on the shared
// MAC unless the output stalls, set by the single read port of the weight and sample memories.
// Further requests wait while the run lasts.
// Reset zeros the history at once through per-row valid bits; weights and biases stay undefined.
module streaming_causal_conv1d
  import scc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coef_addr[9:0], coef_value[41:10], sample[57:42], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result[31:0], filter_index[35:32], zero pad
  output logic        m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  logic                 s_acc;
  cmd_t                 cmd;
  logic [ADDR_IN_W-1:0] coef_addr;
  logic signed [31:0]   coef_value;
  logic signed [15:0]   sample_in;

  logic [CI_W-1:0]      ch_cnt;
  logic [KI_W-1:0]      head;
  logic [FILT_W-1:0]    filt;
  logic [KI_W-1:0]      tap;
  logic [CI_W-1:0]      ch;
  logic [KI_W-1:0]      row;
  logic [WADDR_W-1:0]   waddr;
  logic                 adv;
  logic                 issue;
  logic                 ch_end;
  logic                 tap_end;
  logic                 filt_end;
  logic                 step_in;
  logic                 run_end;
  mac_tag_t             tag0;
  mac_tag_t             tag1;
  logic signed [15:0]   weight_q;
  logic signed [31:0]   bias_q;
  logic signed [15:0]   sample_q;

  // Unpack the request
  assign s_tready   = (state == ST_IDLE);
  assign s_acc      = s_tvalid && s_tready;
  assign cmd        = cmd_t'(s_tuser);
  assign coef_addr  = s_tdata[9:0];
  assign coef_value = s_tdata[41:10];
  assign sample_in  = s_tdata[57:42];

  assign step_in = s_acc && (cmd == CMD_SAMPLE) && (ch_cnt == CI_W'(CHANNELS - 1));

  // Loop ends of the filter, tap and channel counters
  assign issue    = (state == ST_RUN) && adv;
  assign ch_end   = (ch == CI_W'(CHANNELS - 1));
  assign tap_end  = (tap == KI_W'(KERNEL - 1));
  assign filt_end = (filt == FILT_W'(FILTERS - 1));
  assign run_end  = issue && ch_end && tap_end && filt_end;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (step_in) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Channel count of the step being collected, and ring head
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt <= '0;
      head   <= '0;
    end else begin
      if (s_acc && (cmd == CMD_CLEAR)) begin
        ch_cnt <= '0;
      end else if (s_acc && (cmd == CMD_SAMPLE)) begin
        ch_cnt <= (ch_cnt == CI_W'(CHANNELS - 1)) ? '0 : ch_cnt + 1'b1;
      end
      if (run_end) begin
        head <= (head == KI_W'(KERNEL - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  // Walk filters, taps and channels; the tap row steps back through the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= '0;
      tap   <= '0;
      ch    <= '0;
      row   <= '0;
      waddr <= '0;
    end else if (step_in) begin
      filt  <= '0;
      tap   <= '0;
      ch    <= '0;
      row   <= head;
      waddr <= '0;
    end else if (issue) begin
      waddr <= waddr + 1'b1;
      if (ch_end) begin
        ch <= '0;
        if (tap_end) begin
          tap  <= '0;
          row  <= head;
          filt <= filt + 1'b1;
        end else begin
          tap <= tap + 1'b1;
          row <= (row == '0) ? KI_W'(KERNEL - 1) : row - 1'b1;
        end
      end else begin
        ch <= ch + 1'b1;
      end
    end
  end

  // Tag for the read now issued, registered alongside the read data
  always_comb begin
    tag0.vld   = (state == ST_RUN);
    tag0.first = (tap == '0) && (ch == '0);
    tag0.last  = tap_end && ch_end;
    tag0.filt  = filt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (adv) begin
      tag1 <= tag0;
    end
  end

  scc_coef_mem u_coef (
    .clk        (clk),
    .wr_en      (s_acc),
    .cmd        (cmd),
    .coef_addr  (coef_addr),
    .coef_value (coef_value),
    .rd_en      (adv),
    .rd_waddr   (waddr),
    .rd_filt    (filt),
    .weight_q   (weight_q),
    .bias_q     (bias_q)
  );

  scc_sample_mem u_samp (
    .clk        (clk),
    .rst        (rst),
    .clear      (s_acc && (cmd == CMD_CLEAR)),
    .commit     (run_end),
    .commit_row (head),
    .wr_en      (s_acc && (cmd == CMD_SAMPLE)),
    .wr_row     (head),
    .wr_ch      (ch_cnt),
    .wr_data    (sample_in),
    .rd_en      (adv),
    .rd_row     (row),
    .rd_ch      (ch),
    .rd_tap0    (tap == '0),
    .rd_data    (sample_q)
  );

  scc_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .tag1     (tag1),
    .weight   (weight_q),
    .sample   (sample_q),
    .bias     (bias_q),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    run_end |=> (state == ST_IDLE))
    else $error("run did not return to idle after its final multiply");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    step_in |=> ((state == ST_RUN) && (filt == '0) && (waddr == '0) && (row == $past(head))))
    else $error("run started from the wrong position");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    32'(ch_cnt) < CHANNELS)
    else $error("channel count out of range");

endmodule

// ===== tb/sv/conv1d_checker.sv =====
module conv1d_checker
  import scc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // coef_addr[9:0], coef_value[41:10], sample[57:42], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // result[31:0], filter_index[35:32], zero pad
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HIST_LEN   = (KERNEL > 1) ? (KERNEL - 1) * CHANNELS : 1;
  localparam int     MAX_PRINTS = 60;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -SAT_HI - 1;

  typedef struct {
    logic [31:0] result;
    logic [3:0]  filt;
    logic        last;
  } filter_sum_t;

  // Own copy of the layer state
  logic signed [15:0] weights  [TAPS];
  logic signed [31:0] biases   [FILTERS];
  logic signed [15:0] history  [HIST_LEN];   // slot 0 holds the previous time step
  logic signed [15:0] step_now [CHANNELS];
  int                 chan_fill;
  filter_sum_t        filter_sums_q[$];

  task automatic flag_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_history();
    foreach (history[i]) history[i] = '0;
    foreach (step_now[i]) step_now[i] = '0;
    chan_fill = 0;
  endtask

  // Bias plus every tap over the window, saturated once at the end
  function automatic logic [31:0] filter_sum(input int f);
    longint acc;
    longint x;
    acc = longint'(biases[f]);
    for (int k = 0; k < KERNEL; k++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x = (k == 0) ? longint'(step_now[c]) : longint'(history[(k - 1) * CHANNELS + c]);
        acc += x * longint'(weights[(f * KERNEL + k) * CHANNELS + c]);
      end
    end
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    return acc[31:0];
  endfunction

  // Apply one accepted request to the state, queueing any filter sums it completes
  task automatic take_request(input logic [1:0] kind, input logic [63:0] d);
    logic [9:0]  addr;
    logic [31:0] value;
    logic [15:0] smp;
    filter_sum_t e;
    addr  = d[9:0];
    value = d[41:10];
    smp   = d[57:42];
    case (cmd_t'(kind))
      CMD_WEIGHT: begin
        if (addr < TAPS) weights[addr] = value[15:0];
      end
      CMD_BIAS: begin
        if (addr < FILTERS) biases[addr] = value;
      end
      CMD_CLEAR: begin
        clear_history();
      end
      CMD_SAMPLE: begin
        step_now[chan_fill] = smp;
        chan_fill++;
        if (chan_fill == CHANNELS) begin
          chan_fill = 0;
          for (int f = 0; f < FILTERS; f++) begin
            e.result = filter_sum(f);
            e.filt   = 4'(f);
            e.last   = (f == FILTERS - 1);
            filter_sums_q.push_back(e);
          end
          // Age the history by one time step
          for (int i = HIST_LEN - 1; i >= CHANNELS; i--) history[i] = history[i - CHANNELS];
          if (KERNEL > 1) begin
            for (int c = 0; c < CHANNELS; c++) history[c] = step_now[c];
          end
        end
      end
    endcase
  endtask

  // Compare one delivered result with the oldest filter sum
  task automatic take_result();
    filter_sum_t e;
    if (filter_sums_q.size() == 0) begin
      flag_mismatch($sformatf("result %0d for filter %0d with nothing outstanding",
                              $signed(m_tdata[31:0]), m_tdata[35:32]));
      return;
    end
    e = filter_sums_q.pop_front();
    if (m_tdata[31:0] !== e.result)
      flag_mismatch($sformatf("filter %0d result %0d, want %0d", e.filt,
                              $signed(m_tdata[31:0]), $signed(e.result)));
    if (m_tdata[35:32] !== e.filt)
      flag_mismatch($sformatf("filter_index %0d, want %0d", m_tdata[35:32], e.filt));
    if (m_tlast !== e.last)
      flag_mismatch($sformatf("filter %0d last %b, want %b", e.filt, m_tlast, e.last));
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      filter_sums_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) take_result();
      if (s_tvalid && s_tready) take_request(s_tuser, s_tdata);
    end
    pending = filter_sums_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int RAND_ITEMS  = 170;
  localparam int HOLD_CYCLES = 3000;
  localparam int LIMIT       = 800000;
  localparam int TAIL_CYCLES = TAPS + SLOTS + 16;

  typedef enum {PH_STEADY, PH_SEND_GAPS, PH_SINK_STALLS, PH_BOTH} idle_phase_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int idle_pct;
  int stall_pct;
  int hold_asked;
  int sent;
  int fails;
  int pending;
  int cycle_count = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  streaming_causal_conv1d uut (.*);

  conv1d_checker sums_check (
    .fail_count (fails),
    .pending    (pending),
    .*
  );

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is asked for
  initial begin
    int hold_given;
    hold_given = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_given != hold_asked) begin
        hold_given++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void set_phase(input idle_phase_t p);
    case (p)
      PH_STEADY:      begin idle_pct = 0;  stall_pct = 0;  end
      PH_SEND_GAPS:   begin idle_pct = 56; stall_pct = 0;  end
      PH_SINK_STALLS: begin idle_pct = 0;  stall_pct = 56; end
      PH_BOTH:        begin idle_pct = 24; stall_pct = 24; end
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    logic [15:0] w;
    if ($urandom_range(3) == 0) w = 16'($urandom);
    else w = 16'(int'($urandom_range(511)) - 256);
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] s;
    case ($urandom_range(7))
      0:       s = 16'h8000;
      1:       s = 16'h7FFF;
      2:       s = 16'h0000;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  // Hold a request on the bus until it is taken, after a random gap
  task automatic offer(input cmd_t cmd, input logic [9:0] addr, input logic [31:0] value,
                       input logic [15:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, smp, value, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_weight(input logic [9:0] addr, input logic [15:0] w);
    offer(CMD_WEIGHT, addr, {16'($urandom), w}, 16'($urandom));
  endtask

  task automatic write_bias(input logic [9:0] addr, input logic [31:0] b);
    offer(CMD_BIAS, addr, b, 16'($urandom));
  endtask

  task automatic put_sample(input logic [15:0] s);
    offer(CMD_SAMPLE, 10'($urandom), $urandom, s);
  endtask

  task automatic send_clear();
    offer(CMD_CLEAR, 10'($urandom), $urandom, 16'($urandom));
  endtask

  // Drop the request and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] w;
    logic [31:0] b;
    logic [9:0]  addr;
    int          r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_WEIGHT;
    set_phase(PH_STEADY);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load every coefficient: filter 0 all most negative, filter 1 all most positive, filter 2 only
    // channel 0 of the newest tap, filter 3 only the last channel of the oldest tap, the rest random
    set_phase(PH_BOTH);
    for (int f = 0; f < FILTERS; f++) begin
      for (int k = 0; k < KERNEL; k++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          case (f)
            0:       w = 16'h8000;
            1:       w = 16'h7FFF;
            2:       w = (k == 0 && c == 0) ? 16'h7FFF : 16'h0000;
            3:       w = (k == KERNEL - 1 && c == CHANNELS - 1) ? 16'h8000 : 16'h0000;
            default: w = rand_weight();
          endcase
          write_weight(10'((f * KERNEL + k) * CHANNELS + c), w);
        end
      end
    end
    for (int f = 0; f < FILTERS; f++) begin
      case (f)
        0:       b = 32'h7FFF_FFFF;
        1:       b = 32'h8000_0000;
        2:       b = 32'h0000_0000;
        default: b = 32'($signed($urandom) >>> $urandom_range(8));
      endcase
      write_bias(10'(f), b);
    end

    // Directed: saturation both ways, clear mid-step, writes past the tables
    set_phase(PH_STEADY);
    repeat (CHANNELS) put_sample(16'h8000);
    repeat (2) put_sample(16'h7FFF);
    send_clear();
    write_weight(10'd1023, 16'h1234);
    write_weight(10'(TAPS), 16'h7FFF);
    write_bias(10'(FILTERS), 32'h7FFF_FFFF);
    write_bias(10'd1023, 32'h8000_0000);
    write_weight(10'(TAPS - 1), 16'h7FFF);
    write_bias(10'(FILTERS - 1), 32'h8000_0000);
    repeat (CHANNELS) put_sample(16'h7FFF);
    wait_drained();

    // Random traffic, mostly whole time steps, over the idling phases
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      set_phase(idle_phase_t'(ph));
      if (idle_phase_t'(ph) == PH_STEADY) hold_asked++;
      while (sent < (ph + 1) * RAND_ITEMS / 4) begin
        r = $urandom_range(99);
        if (r < 65) begin
          for (int c = 0; c < CHANNELS; c++) begin
            if ($urandom_range(19) == 0) begin
              write_weight(10'($urandom_range(TAPS - 1)), rand_weight());
              sent++;
            end
            put_sample(rand_sample());
            sent++;
          end
        end else if (r < 75) begin
          repeat ($urandom_range(1, CHANNELS - 1)) begin
            put_sample(rand_sample());
            sent++;
          end
        end else if (r < 85) begin
          addr = 10'($urandom_range(1023));
          write_weight(addr, rand_weight());
          if (addr < TAPS) sent++;
        end else if (r < 92) begin
          addr = $urandom_range(1) ? 10'($urandom_range(FILTERS - 1)) : 10'($urandom_range(1023));
          write_bias(addr, $urandom);
          if (addr < FILTERS) sent++;
        end else begin
          send_clear();
          sent++;
        end
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict
    set_phase(PH_STEADY);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
